[rtl/ste_pkg.sv]
// Shared constants, types and step functions for the Sierpinski tetrahedron
// distance pipeline. Used by sierpinski_tetrahedron_distance; no dependencies.
package ste_pkg;

  localparam int MaxIterDef      = 16;
  localparam int CoordFracDef    = 16;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 32;

  localparam int ScaleFrac       = 12;
  localparam logic [14:0] ScaleOne = 15'd4096;
  localparam logic signed [63:0] RoundHalf = 64'sd2048;
  localparam logic signed [63:0] CompMax   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic [47:0] DistMax = 48'h0000_7FFF_FFFF;

  // stage split of the three units
  localparam int FoldStages  = 3;
  localparam int SqStages    = 4;
  localparam int SqrtSteps   = 2;
  localparam int SqrtStages  = 48 / SqrtSteps;
  localparam int DivBits     = 60;
  localparam int DivSteps    = 6;
  localparam int DivStages   = DivBits / DivSteps;

  // bit c set: component c of the vertex is -1
  localparam logic [2:0] VtxNeg [4] = '{3'b000, 3'b011, 3'b110, 3'b101};

  typedef enum logic [CfgIdxW-1:0] {
    RegCentreX = 3'd0,
    RegCentreY = 3'd1,
    RegCentreZ = 3'd2,
    RegFoldCnt = 3'd3,
    RegScale   = 3'd4
  } ste_reg_e;

  typedef struct packed {
    logic [49:0] rem;
    logic [47:0] root;
  } ste_sqrt_t;

  typedef struct packed {
    logic [14:0] rem;
    logic [59:0] nq;
  } ste_div_t;

  // one digit of the restoring square root
  function automatic ste_sqrt_t sqrt_step(ste_sqrt_t cur, logic [1:0] pair);
    logic [51:0] acc;
    logic [51:0] trial;
    ste_sqrt_t   nxt;
    acc   = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      acc      = acc - trial;
      nxt.root = {cur.root[46:0], 1'b1};
    end else begin
      nxt.root = {cur.root[46:0], 1'b0};
    end
    nxt.rem = acc[49:0];
    return nxt;
  endfunction

  // one bit of long division; dividend bits leave the top of nq, quotient
  // bits enter at the bottom
  function automatic ste_div_t div_step(ste_div_t cur, logic [14:0] divisor);
    logic [15:0] acc;
    ste_div_t    nxt;
    acc    = {cur.rem, cur.nq[59]};
    nxt.nq = {cur.nq[58:0], 1'b0};
    if (acc >= {1'b0, divisor}) begin
      acc       = acc - {1'b0, divisor};
      nxt.nq[0] = 1'b1;
    end
    nxt.rem = acc[14:0];
    return nxt;
  endfunction

endpackage

[rtl/sierpinski_tetrahedron_distance.sv]
// Sierpinski tetrahedron distance estimator: fold, length and rescale pipeline.
// Depends on ste_pkg for constants, types and the root and divide step functions.
//
//  channel   signals                                   direction  handshake
//  point     start_i, busy_o, point_{x,y,z}_i          in         start_i & !busy_o
//  result    done_o, distance_o, saturated_o           out        done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_data_i           in         cfg_we_i
//
// One point enters every cycle; busy_o stays low.
// Stages: three per fold, four for the squares, 24 for the root (two digits each)
// and ten per rescale division (six quotient bits each). Unused folds and
// divisions pass data through. Reset clears the valid bits and loads the
// configuration defaults; data registers are not reset. The result side cannot stall.
module sierpinski_tetrahedron_distance #(
  parameter int MAX_ITER        = ste_pkg::MaxIterDef,
  parameter int COORD_FRAC_BITS = ste_pkg::CoordFracDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [31:0]           point_x_i,
  input  logic signed [31:0]           point_y_i,
  input  logic signed [31:0]           point_z_i,
  output logic                         done_o,
  output logic [30:0]                  distance_o,
  output logic                         saturated_o,
  input  logic                         cfg_we_i,
  input  logic [ste_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ste_pkg::CfgDataW-1:0] cfg_data_i
);
  import ste_pkg::*;

  localparam int IterW   = $clog2(MAX_ITER + 1);
  localparam int DivN    = DivStages * MAX_ITER;
  localparam int Latency = 1 + FoldStages * MAX_ITER + SqStages + SqrtStages
                           + DivStages * MAX_ITER + 1;

  // configuration
  logic signed [31:0] centre_x_q, centre_y_q, centre_z_q;
  logic [4:0]         fold_count_q;
  logic [14:0]        scale_factor_q;
  logic [14:0]        scale;
  logic signed [15:0] scale_s;
  logic [IterW-1:0]   iter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q     <= '0;
      centre_y_q     <= '0;
      centre_z_q     <= '0;
      fold_count_q   <= 5'd8;
      scale_factor_q <= 15'd8192;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCentreX: centre_x_q     <= cfg_data_i;
        RegCentreY: centre_y_q     <= cfg_data_i;
        RegCentreZ: centre_z_q     <= cfg_data_i;
        RegFoldCnt: fold_count_q   <= cfg_data_i[4:0];
        RegScale:   scale_factor_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign scale   = (scale_factor_q < ScaleOne) ? ScaleOne : scale_factor_q;
  assign scale_s = $signed({1'b0, scale});
  assign iter    = (32'(fold_count_q) > MAX_ITER) ? IterW'(MAX_ITER) : IterW'(fold_count_q);
  assign busy_o  = 1'b0;

  // fold boundaries: index 0 is the centred point
  logic              fb_vld_q [MAX_ITER+1];
  logic              fb_sat_q [MAX_ITER+1];
  logic signed [47:0] fb_p_q  [MAX_ITER+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fb_vld_q[0] <= 1'b0;
    else         fb_vld_q[0] <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    fb_p_q[0][0] <= 48'(point_x_i) - 48'(centre_x_q);
    fb_p_q[0][1] <= 48'(point_y_i) - 48'(centre_y_q);
    fb_p_q[0][2] <= 48'(point_z_i) - 48'(centre_z_q);
    fb_sat_q[0]  <= 1'b0;
  end

  for (genvar gi = 0; gi < MAX_ITER; gi++) begin : g_fold
    logic               vld1_q, vld2_q, sat1_q, sat2_q;
    logic [1:0]         best1_q, best2_q, best_d;
    logic signed [47:0] p1_q [3];
    logic signed [47:0] p2_q [3];
    logic signed [63:0] prod2_q [3];
    logic signed [49:0] dot [4];
    logic signed [49:0] best_dot;
    logic signed [63:0] vterm;
    logic signed [47:0] pn_d [3];
    logic               sat_d;
    logic               act;

    assign act = IterW'(gi) < iter;

    // nearest vertex is the one with the largest dot product
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        dot[k] = '0;
        for (int c = 0; c < 3; c++) begin
          dot[k] = VtxNeg[k][c] ? dot[k] - 50'(fb_p_q[gi][c])
                                : dot[k] + 50'(fb_p_q[gi][c]);
        end
      end
      best_d   = 2'd0;
      best_dot = dot[0];
      for (int k = 1; k < 4; k++) begin
        if (dot[k] > best_dot) begin
          best_dot = dot[k];
          best_d   = 2'(k);
        end
      end
    end

    always_comb begin
      logic signed [63:0] t;
      logic signed [63:0] r;
      vterm = $signed(64'(scale - ScaleOne) << COORD_FRAC_BITS);
      sat_d = sat2_q;
      for (int c = 0; c < 3; c++) begin
        t = VtxNeg[best2_q][c] ? prod2_q[c] + vterm : prod2_q[c] - vterm;
        r = (t + RoundHalf) >>> ScaleFrac;
        if (r > CompMax) begin
          r = CompMax;
          if (act) sat_d = 1'b1;
        end else if (r < -CompMax) begin
          r = -CompMax;
          if (act) sat_d = 1'b1;
        end
        pn_d[c] = act ? r[47:0] : p2_q[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld1_q          <= 1'b0;
        vld2_q          <= 1'b0;
        fb_vld_q[gi+1]  <= 1'b0;
      end else begin
        vld1_q          <= fb_vld_q[gi];
        vld2_q          <= vld1_q;
        fb_vld_q[gi+1]  <= vld2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      best1_q <= best_d;
      sat1_q  <= fb_sat_q[gi];
      best2_q <= best1_q;
      sat2_q  <= sat1_q;
      for (int c = 0; c < 3; c++) begin
        p1_q[c]         <= fb_p_q[gi][c];
        p2_q[c]         <= p1_q[c];
        prod2_q[c]      <= p1_q[c] * scale_s;
        fb_p_q[gi+1][c] <= pn_d[c];
      end
      fb_sat_q[gi+1] <= sat_d;
    end
  end

  // squared length: magnitude, partial products of the 23-bit upper and 24-bit lower halves, squares, sum
  logic        q1_vld_q, q2_vld_q, q3_vld_q;
  logic        q1_sat_q, q2_sat_q, q3_sat_q;
  logic [46:0] mag_q [3];
  logic [45:0] aa_q  [3];
  logic [46:0] ab_q  [3];
  logic [47:0] bb_q  [3];
  logic [93:0] sqr_q [3];

  logic        sr_vld_q [SqrtStages+1];
  logic        sr_sat_q [SqrtStages+1];
  ste_sqrt_t   sr_st_q  [SqrtStages+1];
  logic [95:0] sr_rad_q [SqrtStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q    <= 1'b0;
      q2_vld_q    <= 1'b0;
      q3_vld_q    <= 1'b0;
      sr_vld_q[0] <= 1'b0;
    end else begin
      q1_vld_q    <= fb_vld_q[MAX_ITER];
      q2_vld_q    <= q1_vld_q;
      q3_vld_q    <= q2_vld_q;
      sr_vld_q[0] <= q3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      mag_q[c] <= fb_p_q[MAX_ITER][c][47] ? 47'(-fb_p_q[MAX_ITER][c])
                                          : 47'(fb_p_q[MAX_ITER][c]);
      aa_q[c]  <= mag_q[c][46:24] * mag_q[c][46:24];
      ab_q[c]  <= mag_q[c][46:24] * mag_q[c][23:0];
      bb_q[c]  <= mag_q[c][23:0] * mag_q[c][23:0];
      sqr_q[c] <= {aa_q[c], 48'b0} + 94'({ab_q[c], 25'b0}) + 94'(bb_q[c]);
    end
    q1_sat_q    <= fb_sat_q[MAX_ITER];
    q2_sat_q    <= q1_sat_q;
    q3_sat_q    <= q2_sat_q;
    sr_sat_q[0] <= q3_sat_q;
    sr_rad_q[0] <= 96'(sqr_q[0]) + 96'(sqr_q[1]) + 96'(sqr_q[2]);
    sr_st_q[0]  <= '0;
  end

  for (genvar gs = 0; gs < SqrtStages; gs++) begin : g_sqrt
    ste_sqrt_t   st_d;
    logic [95:0] rad_d;

    always_comb begin
      st_d  = sr_st_q[gs];
      rad_d = sr_rad_q[gs];
      for (int n = 0; n < SqrtSteps; n++) begin
        st_d  = sqrt_step(st_d, rad_d[95:94]);
        rad_d = rad_d << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_vld_q[gs+1] <= 1'b0;
      else         sr_vld_q[gs+1] <= sr_vld_q[gs];
    end

    always_ff @(posedge clk_i) begin
      sr_st_q[gs+1]  <= st_d;
      sr_rad_q[gs+1] <= rad_d;
      sr_sat_q[gs+1] <= sr_sat_q[gs];
    end
  end

  // rescale: one long division by the scale per active fold, by 1.0 otherwise
  logic     dv_vld_q [DivN];
  logic     dv_sat_q [DivN];
  ste_div_t dv_st_q  [DivN];

  for (genvar gk = 0; gk < DivN; gk++) begin : g_div
    localparam int Fold = gk / DivStages;
    localparam int Step = gk % DivStages;

    logic        vld_in, sat_in;
    ste_div_t    st_in;
    ste_div_t    st_d;
    logic [14:0] divisor;

    if (gk == 0) begin : g_src_root
      assign vld_in = sr_vld_q[SqrtStages];
      assign sat_in = sr_sat_q[SqrtStages];
      assign st_in  = '{rem: '0, nq: {sr_st_q[SqrtStages].root, 12'b0}};
    end else if (Step == 0) begin : g_src_load
      assign vld_in = dv_vld_q[gk-1];
      assign sat_in = dv_sat_q[gk-1];
      assign st_in  = '{rem: '0, nq: {dv_st_q[gk-1].nq[47:0], 12'b0}};
    end else begin : g_src_chain
      assign vld_in = dv_vld_q[gk-1];
      assign sat_in = dv_sat_q[gk-1];
      assign st_in  = dv_st_q[gk-1];
    end

    assign divisor = (IterW'(Fold) < iter) ? scale : ScaleOne;

    always_comb begin
      st_d = st_in;
      for (int n = 0; n < DivSteps; n++) begin
        st_d = div_step(st_d, divisor);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[gk] <= 1'b0;
      else         dv_vld_q[gk] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      dv_st_q[gk]  <= st_d;
      dv_sat_q[gk] <= sat_in;
    end
  end

  // clamp and present the result beat
  logic [47:0] len;
  logic        done_q, saturated_q;
  logic [30:0] distance_q;

  assign len = dv_st_q[DivN-1].nq[47:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_vld_q[DivN-1];
  end

  always_ff @(posedge clk_i) begin
    if (len > DistMax) begin
      distance_q  <= '1;
      saturated_q <= 1'b1;
    end else begin
      distance_q  <= len[30:0];
      saturated_q <= dv_sat_q[DivN-1];
    end
  end

  assign done_o      = done_q;
  assign distance_o  = distance_q;
  assign saturated_o = saturated_q;

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(Latency) done_o)
    else $error("accepted point gave no result beat");

  a_beat_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result beat without an accepted point");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr_vld_q[SqrtStages] |->
      (sr_st_q[SqrtStages].rem <= 50'({sr_st_q[SqrtStages].root, 1'b0})))
    else $error("square root remainder out of bound");

  a_quot_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[DivN-1] |-> (dv_st_q[DivN-1].nq[59:48] == 12'b0))
    else $error("rescale quotient wider than 48 bits");

endmodule
